### src/tga_pkg.sv
// Shared types and codes for the TGA RLE image decoder.
package tga_pkg;

	localparam logic [1:0] KIND_SIZE     = 2'd0;
	localparam logic [1:0] KIND_PIXEL    = 2'd1;
	localparam logic [1:0] KIND_BAD_TYPE = 2'd2;
	localparam logic [1:0] KIND_BAD_BPP  = 2'd3;

	localparam logic [7:0] TYPE_RAW = 8'd2;
	localparam logic [7:0] TYPE_RLE = 8'd10;

	localparam logic [4:0] HDR_ID_LEN   = 5'd0;
	localparam logic [4:0] HDR_TYPE     = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_BPP      = 5'd16;
	localparam logic [4:0] HDR_LAST     = 5'd17;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        has_alpha;
		logic [7:0]  repeat_count;
		logic        last_pixel;
	} result_t;

endpackage

### src/tga_rle_image_decoder.sv
// TGA file byte stream decoder: header parse, ID skip, raw and RLE pixel runs.
// Result beats are registered: the beat that an accepted file byte completes is written into
// the output register, or into the skid register while the output is held.
// Throughput: one file byte per cycle while the skid entry is empty; a two-entry output stage
// (register plus skid) keeps input flowing while one result waits downstream.
// Reset (arst_n low): parser returns to header phase, all counters cleared, output empty.
module tga_rle_image_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  file_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        has_alpha,
	output logic [7:0]  repeat_count,
	output logic        last_pixel
);

	// parser phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_IDSKIP = 3'd1;
	localparam logic [2:0] PH_PACKET = 3'd2;
	localparam logic [2:0] PH_PIXEL  = 3'd3;
	localparam logic [2:0] PH_IDLE   = 3'd4;

	// parser state
	logic [2:0]  phase_q, phase_d;
	logic [4:0]  hdr_idx_q, hdr_idx_d;
	logic [7:0]  id_skip_q, id_skip_d;
	logic [7:0]  img_type_q, img_type_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [4:0]  bpp_q, bpp_d;
	logic        run_q, run_d;
	logic [7:0]  ppl_q, ppl_d;           // pixels left in current packet
	logic [7:0]  pix_q [3];              // B, G, R bytes of the pixel being gathered
	logic [7:0]  pix_d [3];
	logic [1:0]  pix_idx_q, pix_idx_d;
	logic [31:0] remain_q, remain_d;     // pixels still owed to the image

	// output stage: main register plus skid
	tga_pkg::result_t out_q, skid_q, res;
	logic             out_valid_q, skid_valid_q;
	logic             produce;

	logic        accept;
	logic [2:0]  phase_eff;
	logic [4:0]  hdr_idx_eff;
	logic [31:0] area;
	logic        is_rle;
	logic        pix_done;
	logic        run_last;
	logic [7:0]  rep;
	logic        last;
	logic [31:0] remain_after;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	assign area   = 32'(width_q) * 32'(height_q);
	assign is_rle = (img_type_q == tga_pkg::TYPE_RLE);

	// final byte of a pixel when index + 1 reaches bytes per pixel
	assign pix_done = ({3'b000, pix_idx_q} + 5'd1) >= bpp_q;

	// a run that covers the rest of the image is clamped to what remains
	assign run_last     = ({24'd0, ppl_q} >= remain_q);
	assign last         = (is_rle && run_q) ? run_last : (remain_q == 32'd1);
	assign rep          = (is_rle && run_q) ? (run_last ? remain_q[7:0] : ppl_q) : 8'd1;
	assign remain_after = remain_q - 32'(rep);

	always_comb begin
		phase_d    = phase_q;
		hdr_idx_d  = hdr_idx_q;
		id_skip_d  = id_skip_q;
		img_type_d = img_type_q;
		width_d    = width_q;
		height_d   = height_q;
		bpp_d      = bpp_q;
		run_d      = run_q;
		ppl_d      = ppl_q;
		pix_d      = pix_q;
		pix_idx_d  = pix_idx_q;
		remain_d   = remain_q;
		produce    = 1'b0;
		res        = '0;

		// new file restarts the header parse
		phase_eff   = start_of_file ? PH_HEADER : phase_q;
		hdr_idx_eff = start_of_file ? 5'd0 : hdr_idx_q;

		if (accept) begin
			phase_d   = phase_eff;
			hdr_idx_d = hdr_idx_eff;
			unique case (phase_eff)
				PH_HEADER: begin
					unique case (hdr_idx_eff)
						tga_pkg::HDR_ID_LEN:    id_skip_d = file_byte;
						tga_pkg::HDR_TYPE:      img_type_d = file_byte;
						tga_pkg::HDR_WIDTH_LO:  width_d[7:0] = file_byte;
						tga_pkg::HDR_WIDTH_HI:  width_d[15:8] = file_byte;
						tga_pkg::HDR_HEIGHT_LO: height_d[7:0] = file_byte;
						tga_pkg::HDR_HEIGHT_HI: height_d[15:8] = file_byte;
						tga_pkg::HDR_BPP:       bpp_d = file_byte[7:3];
						default: ;
					endcase
					if (hdr_idx_eff < tga_pkg::HDR_LAST) begin
						hdr_idx_d = hdr_idx_eff + 5'd1;
					end else begin
						hdr_idx_d = 5'd0;
						produce   = 1'b1;
						if (img_type_q != tga_pkg::TYPE_RAW && !is_rle) begin
							res.kind = tga_pkg::KIND_BAD_TYPE;
							phase_d  = PH_IDLE;
						end else if (bpp_q != 5'd3 && bpp_q != 5'd4) begin
							res.kind = tga_pkg::KIND_BAD_BPP;
							phase_d  = PH_IDLE;
						end else begin
							res.kind         = tga_pkg::KIND_SIZE;
							res.image_width  = width_q;
							res.image_height = height_q;
							remain_d  = area;
							run_d     = 1'b0;
							ppl_d     = 8'd0;
							pix_idx_d = 2'd0;
							// empty image reads no pixel data
							if (width_q == 16'd0 || height_q == 16'd0)
								phase_d = PH_IDLE;
							else if (id_skip_q != 8'd0)
								phase_d = PH_IDSKIP;
							else
								phase_d = is_rle ? PH_PACKET : PH_PIXEL;
						end
					end
				end
				PH_IDSKIP: begin
					id_skip_d = id_skip_q - 8'd1;
					if (id_skip_q == 8'd1) begin
						pix_idx_d = 2'd0;
						phase_d   = is_rle ? PH_PACKET : PH_PIXEL;
					end
				end
				PH_PACKET: begin
					// raw: low bits + 1 pixels; run: (byte - 127) repeats, same sum
					run_d     = file_byte[7];
					ppl_d     = {1'b0, file_byte[6:0]} + 8'd1;
					pix_idx_d = 2'd0;
					phase_d   = PH_PIXEL;
				end
				PH_PIXEL: begin
					if (!pix_done) begin
						pix_d[pix_idx_q] = file_byte;
						pix_idx_d        = pix_idx_q + 2'd1;
					end else begin
						produce          = 1'b1;
						res.kind         = tga_pkg::KIND_PIXEL;
						res.blue         = pix_q[0];
						res.green        = pix_q[1];
						res.red          = (bpp_q == 5'd4) ? pix_q[2] : file_byte;
						res.alpha        = (bpp_q == 5'd4) ? file_byte : 8'd0;
						res.has_alpha    = (bpp_q == 5'd4);
						res.repeat_count = rep;
						res.last_pixel   = last;
						remain_d         = remain_after;
						pix_idx_d        = 2'd0;
						if (is_rle && run_q)
							ppl_d = 8'd0;
						else if (is_rle && ppl_q != 8'd0)
							ppl_d = ppl_q - 8'd1;
						if (last)
							phase_d = PH_IDLE;
						else if (is_rle && (run_q || ppl_q <= 8'd1))
							phase_d = PH_PACKET;
						else
							phase_d = PH_PIXEL;
					end
				end
				default: ;   // idle: bytes ignored until start of file
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_idx_q  <= '0;
			id_skip_q  <= '0;
			img_type_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			bpp_q      <= '0;
			run_q      <= 1'b0;
			ppl_q      <= '0;
			pix_idx_q  <= '0;
			remain_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			hdr_idx_q  <= hdr_idx_d;
			id_skip_q  <= id_skip_d;
			img_type_q <= img_type_d;
			width_q    <= width_d;
			height_q   <= height_d;
			bpp_q      <= bpp_d;
			run_q      <= run_d;
			ppl_q      <= ppl_d;
			pix_idx_q  <= pix_idx_d;
			remain_q   <= remain_d;
		end
	end

	// pixel byte lanes are payload only
	always_ff @(posedge clk) begin
		pix_q <= pix_d;
	end

	// output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_ready) begin
				if (produce)
					skid_valid_q <= 1'b1;
			end else begin
				out_valid_q  <= skid_valid_q || produce;
				skid_valid_q <= skid_valid_q && produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (produce)
				skid_q <= res;
		end else begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (produce)
					skid_q <= res;
			end else if (produce) begin
				out_q <= res;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign image_width  = out_q.image_width;
	assign image_height = out_q.image_height;
	assign red          = out_q.red;
	assign green        = out_q.green;
	assign blue         = out_q.blue;
	assign alpha        = out_q.alpha;
	assign has_alpha    = out_q.has_alpha;
	assign repeat_count = out_q.repeat_count;
	assign last_pixel   = out_q.last_pixel;

endmodule
